/* src/assert_macros.svh */
// Assertion helpers shared by the compensation block.
// Each check is sampled on the rising edge of clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property holds at every edge.
`define PTC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ptc assertion failed");

// The consequent holds at the same edge as the antecedent.
`define PTC_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptc assertion failed");

// The consequent holds at the next edge after the antecedent.
`define PTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ptc assertion failed");

`else

`define PTC_ASSERT_ALWAYS(lbl, prop)
`define PTC_ASSERT_IMPLIES(lbl, ante, cons)
`define PTC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* src/ptc_pkg.sv */
package ptc_pkg;

  // Field and register widths.
  localparam int RAW_W     = 24;
  localparam int COEF_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W     = 32;

  // Internal datapath widths.
  localparam int DT_W     = 25;  // raw temperature minus reference
  localparam int PROD_W   = 42;  // coefficient times dT
  localparam int DD_W     = 49;  // dT squared, always positive
  localparam int TEMP_W   = 19;  // first-order temperature
  localparam int TI_W     = 17;  // second-order temperature correction
  localparam int TOUT_W   = 20;  // corrected temperature
  localparam int WIDE_W   = 40;  // offset and sensitivity
  localparam int SQ_W     = 36;  // squared temperature deltas
  localparam int HALF_W   = 20;  // split point of the sensitivity word
  localparam int PL_W     = RAW_W + HALF_W;
  localparam int PH_W     = RAW_W + 1 + WIDE_W - HALF_W;
  localparam int PROD64_W = 64;
  localparam int Q_W      = 43;
  localparam int P_W      = 32;

  // Shift amounts of the compensation formulas.
  localparam int TEMP_SHIFT    = 23;
  localparam int OFF_SHIFT     = 7;
  localparam int SENS_SHIFT    = 8;
  localparam int TI_LOW_SHIFT  = 33;
  localparam int TI_HIGH_SHIFT = 36;
  localparam int P_SHIFT_SENS  = 21;
  localparam int P_SHIFT_OUT   = 13;

  // Temperature thresholds in 0.01 degC.
  localparam logic signed [TEMP_W-1:0] TEMP_REF      = TEMP_W'(2000);
  localparam logic signed [TEMP_W-1:0] TEMP_VERY_LOW = TEMP_W'(-1500);

  // Pipeline depths and queue size.
  localparam int FRONT_STAGES = 3;
  localparam int BACK_STAGES  = 7;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = FIFO_PTR_W + 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SENS        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SENS   = CFG_IDX_W'(5);

  // Temperature range that selects the second-order correction.
  typedef enum logic [1:0] {
    RANGE_HIGH,
    RANGE_LOW,
    RANGE_VERY_LOW
  } temp_range_e;

  // Calibration words.
  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] offset;
    logic [COEF_W-1:0] sens_temp;
    logic [COEF_W-1:0] offset_temp;
    logic [COEF_W-1:0] ref_temp;
    logic [COEF_W-1:0] temp_sens;
  } coeff_t;

  // One classified item passed from the front to the back.
  typedef struct packed {
    logic [RAW_W-1:0]         raw_p;
    logic signed [TEMP_W-1:0] temp;
    logic [TI_W-1:0]          ti;
    logic signed [WIDE_W-1:0] off1;
    logic signed [WIDE_W-1:0] sens1;
    temp_range_e              temp_range;
  } front_rec_t;

endpackage

/* src/ptc_front.sv */
`include "assert_macros.svh"

module ptc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ptc_pkg::coeff_t            coeff_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ptc_pkg::RAW_W-1:0]  raw_pressure_i,
  input  logic [ptc_pkg::RAW_W-1:0]  raw_temperature_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ptc_pkg::front_rec_t        out_rec_o
);

  logic [ptc_pkg::FRONT_STAGES-1:0] vld_q, vld_d, en;

  // Stage 1: temperature difference.
  logic [ptc_pkg::RAW_W-1:0]         raw_p1_q;
  logic signed [ptc_pkg::DT_W-1:0]   dt1_q, dt1_d;

  // Stage 2: products with dT.
  logic [ptc_pkg::RAW_W-1:0]         raw_p2_q;
  logic signed [ptc_pkg::PROD_W-1:0] tp2_q, tp2_d, op2_q, op2_d, sp2_q, sp2_d;
  logic signed [2*ptc_pkg::DT_W-1:0] dd_full;
  logic [ptc_pkg::DD_W-1:0]          dd2_q, dd2_d;

  // Stage 3: first-order values and classification.
  logic signed [ptc_pkg::PROD_W-1:0] tsh, osh, ssh;
  logic [ptc_pkg::DD_W:0]            dd3;
  logic signed [ptc_pkg::WIDE_W-1:0] off_base, sens_base;
  ptc_pkg::front_rec_t               rec_q, rec_d;

  // Stall chain: a stage moves when it is empty or its successor moves.
  always_comb begin
    en[ptc_pkg::FRONT_STAGES-1] = !vld_q[ptc_pkg::FRONT_STAGES-1] || out_ready_i;
    for (int k = ptc_pkg::FRONT_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < ptc_pkg::FRONT_STAGES; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage 1 datapath.
  assign dt1_d = $signed({1'b0, raw_temperature_i})
               - $signed({1'b0, coeff_i.ref_temp, 8'h00});

  // Stage 2 datapath.
  assign tp2_d   = dt1_q * $signed({1'b0, coeff_i.temp_sens});
  assign op2_d   = dt1_q * $signed({1'b0, coeff_i.offset_temp});
  assign sp2_d   = dt1_q * $signed({1'b0, coeff_i.sens_temp});
  assign dd_full = dt1_q * dt1_q;
  assign dd2_d   = dd_full[ptc_pkg::DD_W-1:0];

  // Stage 3 datapath.
  always_comb begin
    tsh       = tp2_q >>> ptc_pkg::TEMP_SHIFT;
    osh       = op2_q >>> ptc_pkg::OFF_SHIFT;
    ssh       = sp2_q >>> ptc_pkg::SENS_SHIFT;
    off_base  = $signed({{(ptc_pkg::WIDE_W - ptc_pkg::COEF_W - 16){1'b0}},
                         coeff_i.offset, 16'h0000});
    sens_base = $signed({{(ptc_pkg::WIDE_W - ptc_pkg::COEF_W - 15){1'b0}},
                         coeff_i.sens, 15'h0000});
    dd3       = {1'b0, dd2_q} + {dd2_q, 1'b0};

    rec_d.raw_p = raw_p2_q;
    rec_d.temp  = $signed(tsh[ptc_pkg::TEMP_W-1:0]) + ptc_pkg::TEMP_REF;
    rec_d.off1  = off_base + $signed(osh[ptc_pkg::WIDE_W-1:0]);
    rec_d.sens1 = sens_base + $signed(ssh[ptc_pkg::WIDE_W-1:0]);

    if (rec_d.temp < ptc_pkg::TEMP_REF) begin
      rec_d.ti = ptc_pkg::TI_W'(dd3 >> ptc_pkg::TI_LOW_SHIFT);
      if (rec_d.temp < ptc_pkg::TEMP_VERY_LOW) begin
        rec_d.temp_range = ptc_pkg::RANGE_VERY_LOW;
      end else begin
        rec_d.temp_range = ptc_pkg::RANGE_LOW;
      end
    end else begin
      rec_d.ti         = ptc_pkg::TI_W'(dd2_q >> ptc_pkg::TI_HIGH_SHIFT);
      rec_d.temp_range = ptc_pkg::RANGE_HIGH;
    end
  end

  // Payload registers move with their stage.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      raw_p1_q <= raw_pressure_i;
      dt1_q    <= dt1_d;
    end
    if (en[1]) begin
      raw_p2_q <= raw_p1_q;
      tp2_q    <= tp2_d;
      op2_q    <= op2_d;
      sp2_q    <= sp2_d;
      dd2_q    <= dd2_d;
    end
    if (en[2]) begin
      rec_q <= rec_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[ptc_pkg::FRONT_STAGES-1];
  assign out_rec_o   = rec_q;

  // The range class must agree with the temperature it was taken from.
  `PTC_ASSERT_IMPLIES(a_high_class, out_valid_o && rec_q.temp_range == ptc_pkg::RANGE_HIGH, rec_q.temp >= ptc_pkg::TEMP_REF)
  `PTC_ASSERT_IMPLIES(a_very_low_class, out_valid_o && rec_q.temp_range == ptc_pkg::RANGE_VERY_LOW, rec_q.temp < ptc_pkg::TEMP_VERY_LOW)

endmodule

/* src/ptc_fifo.sv */
`include "assert_macros.svh"

module ptc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ptc_pkg::front_rec_t in_rec_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ptc_pkg::front_rec_t out_rec_o
);

  ptc_pkg::front_rec_t               mem_q [ptc_pkg::FIFO_DEPTH];
  logic [ptc_pkg::FIFO_PTR_W-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [ptc_pkg::FIFO_CNT_W-1:0]    cnt_q, cnt_d;
  logic                              full, push, pop;

  assign full        = (cnt_q == ptc_pkg::FIFO_CNT_W'(ptc_pkg::FIFO_DEPTH));
  assign in_ready_o  = !full;
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && !full;
  assign pop         = out_valid_o && out_ready_i;
  assign out_rec_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_rec_i;
    end
  end

  `PTC_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= ptc_pkg::FIFO_CNT_W'(ptc_pkg::FIFO_DEPTH))
  `PTC_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
  `PTC_ASSERT_NEXT(a_empty_hold, cnt_q == '0 && !in_valid_i, cnt_q == '0)

endmodule

/* src/ptc_back.sv */
module ptc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ptc_pkg::front_rec_t        in_rec_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ptc_pkg::OUT_W-1:0]  pressure_pa_o,
  output logic [ptc_pkg::OUT_W-1:0]  temperature_centi_o
);

  logic [ptc_pkg::BACK_STAGES-1:0] vld_q, vld_d, en;

  // Stage 1: squared temperature deltas and final temperature.
  logic signed [ptc_pkg::TEMP_W-1:0]   dlt, dvl;
  logic signed [2*ptc_pkg::TEMP_W-1:0] sq_dlt_full, sq_dvl_full;
  logic [ptc_pkg::SQ_W-1:0]            sq_dlt1_q, sq_dvl1_q;
  logic signed [ptc_pkg::TOUT_W-1:0]   tout1_q, tout1_d;
  logic [ptc_pkg::RAW_W-1:0]           raw_p1_q;
  logic signed [ptc_pkg::WIDE_W-1:0]   off1_1_q, sens1_1_q;
  ptc_pkg::temp_range_e                range1_q;

  // Stage 2: second-order offset and sensitivity terms.
  logic [ptc_pkg::WIDE_W-1:0]          sqe, sve, sq3, sq5, sv7;
  logic [ptc_pkg::WIDE_W-1:0]          offi2_q, offi2_d, sensi2_q, sensi2_d;
  logic signed [ptc_pkg::TOUT_W-1:0]   tout2_q;
  logic [ptc_pkg::RAW_W-1:0]           raw_p2_q;
  logic signed [ptc_pkg::WIDE_W-1:0]   off1_2_q, sens1_2_q;

  // Stage 3: corrected offset and sensitivity.
  logic signed [ptc_pkg::WIDE_W-1:0]   off3_q, off3_d, sens3_q, sens3_d;
  logic signed [ptc_pkg::TOUT_W-1:0]   tout3_q;
  logic [ptc_pkg::RAW_W-1:0]           raw_p3_q;

  // Stage 4: partial products of pressure times sensitivity.
  logic [ptc_pkg::PL_W-1:0]            pl4_q, pl4_d;
  logic signed [ptc_pkg::PH_W-1:0]     ph4_q, ph4_d;
  logic signed [ptc_pkg::WIDE_W-1:0]   off4_q;
  logic signed [ptc_pkg::TOUT_W-1:0]   tout4_q;

  // Stage 5: full product, scaled.
  logic signed [ptc_pkg::PROD64_W-1:0] prod;
  logic signed [ptc_pkg::Q_W-1:0]      q5_q, q5_d;
  logic signed [ptc_pkg::WIDE_W-1:0]   off5_q;
  logic signed [ptc_pkg::TOUT_W-1:0]   tout5_q;

  // Stage 6: offset removed and scaled.
  logic signed [ptc_pkg::Q_W:0]        tdiff;
  logic signed [ptc_pkg::P_W-1:0]      p6_q, p6_d;
  logic signed [ptc_pkg::TOUT_W-1:0]   tout6_q;

  // Stage 7: output register.
  logic [ptc_pkg::OUT_W-1:0]           press7_q, press7_d, temp7_q, temp7_d;

  // Stall chain from the output register back to the queue.
  always_comb begin
    en[ptc_pkg::BACK_STAGES-1] = !vld_q[ptc_pkg::BACK_STAGES-1] || out_ready_i;
    for (int k = ptc_pkg::BACK_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < ptc_pkg::BACK_STAGES; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage 1 datapath.
  always_comb begin
    dlt         = in_rec_i.temp - ptc_pkg::TEMP_REF;
    dvl         = in_rec_i.temp - ptc_pkg::TEMP_VERY_LOW;
    sq_dlt_full = dlt * dlt;
    sq_dvl_full = dvl * dvl;
    tout1_d     = $signed({in_rec_i.temp[ptc_pkg::TEMP_W-1], in_rec_i.temp})
                - $signed({{(ptc_pkg::TOUT_W - ptc_pkg::TI_W){1'b0}}, in_rec_i.ti});
  end

  // Stage 2 datapath: correction terms per temperature range.
  always_comb begin
    sqe = {{(ptc_pkg::WIDE_W - ptc_pkg::SQ_W){1'b0}}, sq_dlt1_q};
    sve = {{(ptc_pkg::WIDE_W - ptc_pkg::SQ_W){1'b0}}, sq_dvl1_q};
    sq3 = sqe + (sqe << 1);
    sq5 = sqe + (sqe << 2);
    sv7 = (sve << 3) - sve;
    case (range1_q)
      ptc_pkg::RANGE_HIGH: begin
        offi2_d  = sqe >> 4;
        sensi2_d = '0;
      end
      ptc_pkg::RANGE_LOW: begin
        offi2_d  = sq3 >> 1;
        sensi2_d = sq5 >> 3;
      end
      ptc_pkg::RANGE_VERY_LOW: begin
        offi2_d  = (sq3 >> 1) + sv7;
        sensi2_d = (sq5 >> 3) + (sve << 2);
      end
      default: begin
        offi2_d  = '0;
        sensi2_d = '0;
      end
    endcase
  end

  // Stage 3 datapath.
  assign off3_d  = off1_2_q - $signed(offi2_q);
  assign sens3_d = sens1_2_q - $signed(sensi2_q);

  // Stage 4 datapath: the wide product is split at the sensitivity midpoint.
  assign pl4_d = raw_p3_q * sens3_q[ptc_pkg::HALF_W-1:0];
  assign ph4_d = $signed({1'b0, raw_p3_q})
               * $signed(sens3_q[ptc_pkg::WIDE_W-1:ptc_pkg::HALF_W]);

  // Stage 5 datapath.
  always_comb begin
    prod = $signed({ph4_q[ptc_pkg::PROD64_W-ptc_pkg::HALF_W-1:0], {ptc_pkg::HALF_W{1'b0}}})
         + $signed({{(ptc_pkg::PROD64_W - ptc_pkg::PL_W){1'b0}}, pl4_q});
    q5_d = ptc_pkg::Q_W'(prod >>> ptc_pkg::P_SHIFT_SENS);
  end

  // Stage 6 datapath.
  always_comb begin
    tdiff = $signed({q5_q[ptc_pkg::Q_W-1], q5_q})
          - $signed({{(ptc_pkg::Q_W + 1 - ptc_pkg::WIDE_W){off5_q[ptc_pkg::WIDE_W-1]}}, off5_q});
    p6_d  = ptc_pkg::P_W'(tdiff >>> ptc_pkg::P_SHIFT_OUT);
  end

  // Stage 7 datapath: pascal is ten times the scaled value.
  always_comb begin
    press7_d = (p6_q <<< 3) + (p6_q <<< 1);
    temp7_d  = {{(ptc_pkg::OUT_W - ptc_pkg::TOUT_W){tout6_q[ptc_pkg::TOUT_W-1]}}, tout6_q};
  end

  // Payload registers move with their stage.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      sq_dlt1_q <= sq_dlt_full[ptc_pkg::SQ_W-1:0];
      sq_dvl1_q <= sq_dvl_full[ptc_pkg::SQ_W-1:0];
      tout1_q   <= tout1_d;
      raw_p1_q  <= in_rec_i.raw_p;
      off1_1_q  <= in_rec_i.off1;
      sens1_1_q <= in_rec_i.sens1;
      range1_q  <= in_rec_i.temp_range;
    end
    if (en[1]) begin
      offi2_q   <= offi2_d;
      sensi2_q  <= sensi2_d;
      tout2_q   <= tout1_q;
      raw_p2_q  <= raw_p1_q;
      off1_2_q  <= off1_1_q;
      sens1_2_q <= sens1_1_q;
    end
    if (en[2]) begin
      off3_q   <= off3_d;
      sens3_q  <= sens3_d;
      tout3_q  <= tout2_q;
      raw_p3_q <= raw_p2_q;
    end
    if (en[3]) begin
      pl4_q   <= pl4_d;
      ph4_q   <= ph4_d;
      off4_q  <= off3_q;
      tout4_q <= tout3_q;
    end
    if (en[4]) begin
      q5_q    <= q5_d;
      off5_q  <= off4_q;
      tout5_q <= tout4_q;
    end
    if (en[5]) begin
      p6_q    <= p6_d;
      tout6_q <= tout5_q;
    end
    if (en[6]) begin
      press7_q <= press7_d;
      temp7_q  <= temp7_d;
    end
  end

  assign in_ready_o          = en[0];
  assign out_valid_o         = vld_q[ptc_pkg::BACK_STAGES-1];
  assign pressure_pa_o       = press7_q;
  assign temperature_centi_o = temp7_q;

endmodule

/* src/pressure_temperature_compensation.sv */
// Second-order compensation for a barometric pressure sensor. Each input transfer
// carries one raw 24-bit pressure and temperature conversion pair; each output
// transfer returns the compensated pressure in Pa and temperature in 0.01 degC,
// both as the low 32 bits of the exact result. The block takes one transfer per
// clock cycle when the output side keeps up. An accepted input passes through 3 front
// stages (dT, products with dT, first-order values with range classification), the
// four-entry queue and 7 back stages (squares, correction terms, corrections, split
// 24x40 product, product sum, offset removal, output register). The longest single
// stage is one multiplier of at most 25x25 bits. The six calibration words reset to
// zero; the user must write them through the cfg port only while no item is in
// flight, as the block itself does not enforce it.
module pressure_temperature_compensation (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Calibration register writes.
  input  logic                           cfg_we_i,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ptc_pkg::COEF_W-1:0]     cfg_wdata_i,
  // Raw conversion input.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [47:0]                    s_axis_tdata,  // [23:0] raw_pressure, [47:24] raw_temperature
  // Compensated result output.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [63:0]                    m_axis_tdata   // [31:0] pressure_pa, [63:32] temperature_centi
);

  ptc_pkg::coeff_t     coeff_q, coeff_d;
  ptc_pkg::front_rec_t front_rec, fifo_rec;
  logic                front_valid, front_ready, fifo_valid, fifo_ready;
  logic [ptc_pkg::OUT_W-1:0] pressure_pa, temperature_centi;

  // Calibration register file; writes to unused indexes are dropped.
  always_comb begin
    coeff_d = coeff_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        ptc_pkg::REG_SENS:        coeff_d.sens        = cfg_wdata_i;
        ptc_pkg::REG_OFFSET:      coeff_d.offset      = cfg_wdata_i;
        ptc_pkg::REG_SENS_TEMP:   coeff_d.sens_temp   = cfg_wdata_i;
        ptc_pkg::REG_OFFSET_TEMP: coeff_d.offset_temp = cfg_wdata_i;
        ptc_pkg::REG_REF_TEMP:    coeff_d.ref_temp    = cfg_wdata_i;
        ptc_pkg::REG_TEMP_SENS:   coeff_d.temp_sens   = cfg_wdata_i;
        default:                  coeff_d = coeff_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
    end else begin
      coeff_q <= coeff_d;
    end
  end

  // Front: accepts conversions and classifies the temperature range.
  ptc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .coeff_i           (coeff_q),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .raw_pressure_i    (s_axis_tdata[23:0]),
    .raw_temperature_i (s_axis_tdata[47:24]),
    .out_valid_o       (front_valid),
    .out_ready_i       (front_ready),
    .out_rec_o         (front_rec)
  );

  // Queue between the two halves.
  ptc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_rec_i    (front_rec),
    .out_valid_o (fifo_valid),
    .out_ready_i (fifo_ready),
    .out_rec_o   (fifo_rec)
  );

  // Back: second-order correction and pressure calculation.
  ptc_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (fifo_valid),
    .in_ready_o          (fifo_ready),
    .in_rec_i            (fifo_rec),
    .out_valid_o         (m_axis_tvalid),
    .out_ready_i         (m_axis_tready),
    .pressure_pa_o       (pressure_pa),
    .temperature_centi_o (temperature_centi)
  );

  assign m_axis_tdata = {temperature_centi, pressure_pa};

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  // Conversion pair as it travels on s_axis_tdata, raw pressure in the low bits.
  typedef struct packed {
    logic [ptc_pkg::RAW_W-1:0] raw_temperature;
    logic [ptc_pkg::RAW_W-1:0] raw_pressure;
  } conversion_t;

  // Compensated pair as it travels on m_axis_tdata, pressure in the low bits.
  typedef struct packed {
    logic signed [ptc_pkg::OUT_W-1:0] temperature_centi;
    logic signed [ptc_pkg::OUT_W-1:0] pressure_pa;
  } reading_t;

  localparam int PIPE_LATENCY = 12;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int IDLE_PCT = 14;
  localparam int PHASE_ITEMS = 180;
  localparam int RANDOM_PHASES = 8;

  // Indexes past the last calibration word; writes there must be dropped.
  localparam logic [ptc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = ptc_pkg::CFG_IDX_W'(6);
  localparam logic [ptc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = ptc_pkg::CFG_IDX_W'(7);

  localparam ptc_pkg::coeff_t TYPICAL_CAL = '{
    sens:        16'd34982,
    offset:      16'd36352,
    sens_temp:   16'd20328,
    offset_temp: 16'd22354,
    ref_temp:    16'd26646,
    temp_sens:   16'd26146
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ptc_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ptc_pkg::COEF_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  ptc_pkg::coeff_t cal_words = '0;
  conversion_t pending_conv[$];
  reading_t expected_readings[$];
  reading_t got_reading;
  reading_t want_reading;
  int idle_pct = IDLE_PCT;
  bit hold_sender = 1'b0;
  bit rx_hold_req = 1'b0;
  int rx_hold_left = 0;
  bit conv_taken = 1'b0;
  int quiet_cycles = 0;
  int error_count = 0;

  pressure_temperature_compensation DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Second-order compensation of one conversion pair with the current calibration.
  function automatic reading_t compensate(logic [ptc_pkg::RAW_W-1:0] rp,
                                          logic [ptc_pkg::RAW_W-1:0] rt);
    longint c_sens, c_off, c_sens_t, c_off_t, c_ref, c_tsens;
    longint d1, d2, dt, temp, off, sens, ti, offi, sensi, p, dlt, dvl;
    reading_t r;
    c_sens   = cal_words.sens;
    c_off    = cal_words.offset;
    c_sens_t = cal_words.sens_temp;
    c_off_t  = cal_words.offset_temp;
    c_ref    = cal_words.ref_temp;
    c_tsens  = cal_words.temp_sens;
    d1 = rp;
    d2 = rt;
    dt = d2 - c_ref * 256;
    temp = 2000 + ((dt * c_tsens) >>> 23);
    off = c_off * 65536 + ((c_off_t * dt) >>> 7);
    sens = c_sens * 32768 + ((c_sens_t * dt) >>> 8);
    dlt = temp - 2000;
    if (temp < 2000) begin
      ti = (3 * dt * dt) >>> 33;
      offi = (3 * dlt * dlt) / 2;
      sensi = (5 * dlt * dlt) / 8;
      // Very low range adds a further correction on top of the low one.
      if (temp < -1500) begin
        dvl = temp + 1500;
        offi += 7 * dvl * dvl;
        sensi += 4 * dvl * dvl;
      end
    end else begin
      ti = (2 * dt * dt) >>> 37;
      offi = (dlt * dlt) / 16;
      sensi = 0;
    end
    off -= offi;
    sens -= sensi;
    p = (((d1 * sens) >>> 21) - off) >>> 13;
    r.pressure_pa = ptc_pkg::OUT_W'(p * 10);
    r.temperature_centi = ptc_pkg::OUT_W'(temp - ti);
    return r;
  endfunction

  // Raw temperature at which the first-order temperature first reaches target.
  function automatic logic [ptc_pkg::RAW_W-1:0] raw_temp_at(int target);
    longint x, tsens, dt;
    x = longint'(target - 2000) <<< 23;
    tsens = cal_words.temp_sens;
    if (x >= 0) begin
      dt = (x + tsens - 1) / tsens;
    end else begin
      dt = -((-x) / tsens);
    end
    return ptc_pkg::RAW_W'(longint'(cal_words.ref_temp) * 256 + dt);
  endfunction

  task automatic write_coeff(logic [ptc_pkg::CFG_IDX_W-1:0] idx,
                             logic [ptc_pkg::COEF_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      ptc_pkg::REG_SENS:        cal_words.sens = val;
      ptc_pkg::REG_OFFSET:      cal_words.offset = val;
      ptc_pkg::REG_SENS_TEMP:   cal_words.sens_temp = val;
      ptc_pkg::REG_OFFSET_TEMP: cal_words.offset_temp = val;
      ptc_pkg::REG_REF_TEMP:    cal_words.ref_temp = val;
      ptc_pkg::REG_TEMP_SENS:   cal_words.temp_sens = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_calibration(ptc_pkg::coeff_t c);
    write_coeff(ptc_pkg::REG_SENS, c.sens);
    write_coeff(ptc_pkg::REG_OFFSET, c.offset);
    write_coeff(ptc_pkg::REG_SENS_TEMP, c.sens_temp);
    write_coeff(ptc_pkg::REG_OFFSET_TEMP, c.offset_temp);
    write_coeff(ptc_pkg::REG_REF_TEMP, c.ref_temp);
    write_coeff(ptc_pkg::REG_TEMP_SENS, c.temp_sens);
  endtask

  task automatic push_conv(logic [ptc_pkg::RAW_W-1:0] rp, logic [ptc_pkg::RAW_W-1:0] rt);
    conversion_t c;
    c.raw_pressure = rp;
    c.raw_temperature = rt;
    pending_conv.push_back(c);
  endtask

  // Wait until every conversion has been sent and every reading has come back.
  task automatic drain;
    while (pending_conv.size() != 0 || s_axis_tvalid || expected_readings.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (PIPE_LATENCY) @(posedge clk_i);
  endtask

  // Driver: offers the next pending conversion once the previous one has gone.
  always @(negedge clk_i) begin
    if (rst_ni && (conv_taken || !s_axis_tvalid)) begin
      conv_taken = 1'b0;
      if (pending_conv.size() != 0 && !hold_sender && $urandom_range(99) >= idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_conv.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_left = RX_HOLD_CYCLES;
      rx_hold_req = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Monitor: predicts each accepted conversion and checks each returned reading.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_readings.push_back(compensate(s_axis_tdata[23:0], s_axis_tdata[47:24]));
        conv_taken = 1'b1;
        quiet_cycles = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_cycles = 0;
        got_reading = m_axis_tdata;
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading pressure %0d temperature %0d", $time,
                   got_reading.pressure_pa, got_reading.temperature_centi);
          error_count++;
        end else begin
          want_reading = expected_readings.pop_front();
          if (got_reading.pressure_pa !== want_reading.pressure_pa) begin
            $display("%0t: pressure_pa expected %0d actual %0d", $time,
                     want_reading.pressure_pa, got_reading.pressure_pa);
            error_count++;
          end
          if (got_reading.temperature_centi !== want_reading.temperature_centi) begin
            $display("%0t: temperature_centi expected %0d actual %0d", $time,
                     want_reading.temperature_centi, got_reading.temperature_centi);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: too long without any transfer means the block has hung.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("pressure_temperature_compensation: mismatch");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    ptc_pkg::coeff_t cal;
    logic [ptc_pkg::RAW_W-1:0] rt;
    int dt_span;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Uncalibrated block: all words still at their reset value.
    push_conv('0, '0);
    push_conv('1, '1);
    push_conv('0, '1);
    push_conv('1, '0);
    drain();

    // Every word at its maximum; spare indexes must not disturb anything.
    write_calibration('1);
    write_coeff(REG_SPARE_LO, 16'h1234);
    write_coeff(REG_SPARE_HI, '0);
    push_conv('0, '0);
    push_conv('1, '1);
    push_conv('0, '1);
    push_conv('1, '0);
    drain();

    // Typical calibration, items placed on both range thresholds.
    write_calibration(TYPICAL_CAL);
    push_conv(24'd6465444, raw_temp_at(2000));
    push_conv(24'd6465444, raw_temp_at(2000) - 24'd1);
    push_conv(24'd6465444, raw_temp_at(-1500));
    push_conv(24'd6465444, raw_temp_at(-1500) - 24'd1);
    push_conv('1, raw_temp_at(-1500) - 24'd1);
    push_conv('0, raw_temp_at(2000));
    push_conv('1, '1);
    push_conv(24'd6465444, '0);
    drain();

    // Random phases, each with its own calibration.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      for (int w = 0; w < 6; w++) begin
        case (ph % 4)
          0, 3: cal[w*ptc_pkg::COEF_W +: ptc_pkg::COEF_W] = ptc_pkg::COEF_W'($urandom);
          1: cal[w*ptc_pkg::COEF_W +: ptc_pkg::COEF_W] =
               TYPICAL_CAL[w*ptc_pkg::COEF_W +: ptc_pkg::COEF_W]
               + ptc_pkg::COEF_W'($urandom_range(4000)) - 16'd2000;
          default: cal[w*ptc_pkg::COEF_W +: ptc_pkg::COEF_W] = $urandom_range(1) ? '1 : '0;
        endcase
      end
      write_calibration(cal);
      if (ph == 5) begin
        write_coeff($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                    ptc_pkg::COEF_W'($urandom));
      end
      // Near the reference most items land around the range thresholds.
      dt_span = (cal_words.temp_sens > 16'd2000) ? (1 << 21) : (1 << 23);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < 60) begin
          rt = ptc_pkg::RAW_W'(longint'(cal_words.ref_temp) * 256
                               + longint'($urandom_range(2 * dt_span)) - dt_span);
        end else begin
          rt = ptc_pkg::RAW_W'($urandom);
        end
        push_conv(ptc_pkg::RAW_W'($urandom), rt);
      end
      if (ph == 2) begin
        idle_pct = 0;
      end
      if (ph == 4) begin
        rx_hold_req = 1'b1;
      end
      if (ph == 6) begin
        // Sender stops mid-phase until the pipeline has emptied.
        while (pending_conv.size() > PHASE_ITEMS / 2) @(posedge clk_i);
        hold_sender = 1'b1;
        while (s_axis_tvalid || expected_readings.size() != 0) @(posedge clk_i);
        repeat (PIPE_LATENCY) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      drain();
      idle_pct = IDLE_PCT;
    end

    if (expected_readings.size() != 0) begin
      $display("%0t: %0d readings never arrived", $time, expected_readings.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("pressure_temperature_compensation: match");
    end else begin
      $display("pressure_temperature_compensation: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/ptc_pkg.sv
src/ptc_front.sv
src/ptc_fifo.sv
src/ptc_back.sv
src/pressure_temperature_compensation.sv
verif/testbench.sv
